### hdl/aic_pkg.sv
// Shared types and constants for the accumulator integer calculator.
package aic_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH    = 32;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_REM  = 3'd4,
        OP_POW  = 3'd5,
        OP_SQRT = 3'd6,
        OP_CBRT = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_DIV_ZERO = 2'd1,
        ERR_NEG_ROOT = 2'd2,
        ERR_OVERFLOW = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        EOP_MUL,
        EOP_DIV,
        EOP_SQRT,
        EOP_CBRT
    } t_eng_op;

    typedef struct packed {
        logic    start;
        t_eng_op op;
    } t_eng_req;

    typedef enum logic [1:0] {
        ES_IDLE,
        ES_RUN,
        ES_CUBE_T,
        ES_DONE
    } t_eng_state;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAIT,
        ST_POW_MUL,
        ST_POW_WAIT,
        ST_DONE
    } t_top_state;

endpackage

### hdl/aic_if.sv
// Valid/ready channel interfaces for the calculator's input and result streams.
interface aic_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, opcode, operand_a, operand_b, input ready);
    modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface aic_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [1:0]         error_code;

    modport source (output valid, result_value, error_code, input ready);
    modport sink   (input valid, result_value, error_code, output ready);
endinterface

### hdl/aic_engine.sv
// Iterative arithmetic unit: shift-add multiply, restoring divide, square and cube root.
module aic_engine #(
    parameter int DATA_WIDTH = aic_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  aic_pkg::t_eng_req     i_req,
    input  logic [DATA_WIDTH-1:0] i_x,
    input  logic [DATA_WIDTH-1:0] i_y,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_lo,
    output logic [DATA_WIDTH-1:0] o_hi
);
    import aic_pkg::*;

    localparam int DW       = DATA_WIDTH;
    localparam int SQ_STEPS = (DW + 1) / 2;
    localparam int CB_STEPS = (DW + 2) / 3;
    localparam int YW       = CB_STEPS + 1;
    localparam int TW       = 2 * YW + 2;
    localparam int MW       = (DW > TW) ? DW : TW;
    localparam int CNW      = $clog2(DW + 1);
    localparam int SHW      = $clog2(DW);
    localparam int SQ_TOP   = 2 * SQ_STEPS - 2;
    localparam int CB_TOP   = 3 * CB_STEPS - 3;

    t_eng_state r_state, n_state;
    t_eng_op    r_op;
    logic [CNW-1:0]  r_cnt;
    logic [2*DW-1:0] r_acc, r_mc;
    logic [DW-1:0]   r_mp, r_rem, r_quo, r_div, r_x;
    logic [DW:0]     r_res, r_bit;
    logic [YW-1:0]   r_y;
    logic [TW-1:0]   r_t;
    logic [SHW-1:0]  r_s;

    logic [DW:0]     div_sh, div_diff, sq_sum;
    logic            sq_ge, cb_ge;
    logic [YW-1:0]   cb_y2;
    logic [2*YW-1:0] cb_prod;
    logic [TW-1:0]   cb_t;
    logic [DW-1:0]   cb_xs, cb_sub;

    assign div_sh   = {r_rem, r_quo[DW-1]};
    assign div_diff = div_sh - {1'b0, r_div};
    assign sq_sum   = r_res + r_bit;
    assign sq_ge    = {1'b0, r_x} >= sq_sum;
    assign cb_y2    = {r_y[YW-2:0], 1'b0};
    assign cb_prod  = {{YW{1'b0}}, cb_y2} * {{YW{1'b0}}, YW'(cb_y2 + YW'(1))};
    // t = 3*y*(y+1) + 1
    assign cb_t     = TW'({cb_prod, 1'b0}) + TW'(cb_prod) + TW'(1);
    assign cb_xs    = r_x >> r_s;
    assign cb_ge    = MW'(cb_xs) >= MW'(r_t);
    assign cb_sub   = r_x - (DW'(r_t) << r_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ES_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ES_IDLE: begin
                if (i_req.start) begin
                    n_state = (i_req.op == EOP_CBRT) ? ES_CUBE_T : ES_RUN;
                end
            end
            ES_RUN: begin
                if (r_cnt == CNW'(1)) begin
                    n_state = ES_DONE;
                end else if (r_op == EOP_CBRT) begin
                    n_state = ES_CUBE_T;
                end
            end
            ES_CUBE_T: n_state = ES_RUN;
            ES_DONE:   n_state = ES_IDLE;
            default:   n_state = ES_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == ES_DONE);
        unique case (r_op)
            EOP_MUL:  o_lo = r_acc[DW-1:0];
            EOP_DIV:  o_lo = r_quo;
            EOP_SQRT: o_lo = r_res[DW-1:0];
            EOP_CBRT: o_lo = DW'(r_y);
            default:  o_lo = r_quo;
        endcase
        o_hi = (r_op == EOP_MUL) ? r_acc[2*DW-1:DW] : r_rem;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ES_IDLE: begin
                if (i_req.start) begin
                    r_op  <= i_req.op;
                    r_acc <= '0;
                    r_mc  <= {{DW{1'b0}}, i_x};
                    r_mp  <= i_y;
                    r_rem <= '0;
                    r_quo <= i_x;
                    r_div <= i_y;
                    r_x   <= i_x;
                    r_res <= '0;
                    r_bit <= (DW + 1)'(1) << SQ_TOP;
                    r_y   <= '0;
                    r_s   <= SHW'(CB_TOP);
                    case (i_req.op)
                        EOP_SQRT: r_cnt <= CNW'(SQ_STEPS);
                        EOP_CBRT: r_cnt <= CNW'(CB_STEPS);
                        default:  r_cnt <= CNW'(DW);
                    endcase
                end
            end
            ES_CUBE_T: begin
                r_y <= cb_y2;
                r_t <= cb_t;
            end
            ES_RUN: begin
                r_cnt <= r_cnt - CNW'(1);
                case (r_op)
                    EOP_MUL: begin
                        if (r_mp[0]) begin
                            r_acc <= r_acc + r_mc;
                        end
                        r_mc <= r_mc << 1;
                        r_mp <= r_mp >> 1;
                    end
                    EOP_DIV: begin
                        r_rem <= div_diff[DW] ? div_sh[DW-1:0] : div_diff[DW-1:0];
                        r_quo <= {r_quo[DW-2:0], ~div_diff[DW]};
                    end
                    EOP_SQRT: begin
                        if (sq_ge) begin
                            r_x   <= r_x - sq_sum[DW-1:0];
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                    default: begin
                        if (cb_ge) begin
                            r_x <= cb_sub;
                            r_y <= r_y + YW'(1);
                        end
                        r_s <= r_s - SHW'(3);
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

endmodule

### hdl/accumulator_integer_calculator.sv
// Accumulator integer calculator: operand selection, sequencer and result register.
//
// Input channel i_in carries opcode, operand_a and operand_b; result channel o_out
// carries result_value and error_code, one result per input transfer. Either
// operand equal to zero is replaced by the stored previous answer.
// The block takes one item at a time; i_in.ready is high only while idle.
// Add and sub finish in the sequencer; mul, div and rem run the shift-add or
// restoring engine, one bit per cycle; sqrt and cbrt run the root iterations
// in the engine; pow runs one shift-add multiply per exponent step, at most
// DATA_WIDTH steps before overflow.
// The next input transfer is taken only after a result is registered and the
// sequencer has returned to idle.
// All multi-cycle work runs through the one shared iterative engine.
// Errors (divide by zero, negative root) return 0 and keep the previous answer.
// Reset clears the previous answer to 0 and empties the result register.
// A finished result waits in the output register; a new item may be taken while
// it waits, but the next result is held back until the receiver takes the first.
module accumulator_integer_calculator #(
    parameter int DATA_WIDTH = aic_pkg::DATA_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    aic_in_if.sink         i_in,
    aic_out_if.source      o_out
);
    import aic_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam logic [DW-1:0] WMAX  = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] WSIGN = {1'b1, {(DW-1){1'b0}}};

    t_top_state r_state, n_state;
    t_opcode    r_op;
    logic [DW-1:0] r_a, r_b, r_prev, r_res, r_m, r_ma, r_cnt;
    t_err          r_err;
    logic          r_store, r_rneg, r_ov;
    logic [FIELD_WIDTH-1:0] r_out_val;
    t_err          r_out_err;

    logic [DW-1:0] a_w, b_w, ma, mb, eng_x, eng_y, eng_lo, eng_hi;
    logic          a_neg, b_neg, b_zero, eng_done, out_free, pow_ovf;
    logic [2*DW-1:0] pow_prod, pow_lim;
    t_eng_req      eng_req;
    logic [DW-1:0] ex_res;
    t_err          ex_err;
    logic          ex_store;

    function automatic logic [DW-1:0] sgn(input logic n, input logic [DW-1:0] m);
        return n ? (DW'(0) - m) : m;
    endfunction

    assign a_w      = DW'(i_in.operand_a);
    assign b_w      = DW'(i_in.operand_b);
    assign a_neg    = r_a[DW-1];
    assign b_neg    = r_b[DW-1];
    assign b_zero   = (r_b == '0);
    assign ma       = sgn(a_neg, r_a);
    assign mb       = sgn(b_neg, r_b);
    assign out_free = !r_ov || o_out.ready;
    assign pow_prod = {eng_hi, eng_lo};
    assign pow_lim  = (2*DW)'(r_rneg ? WSIGN : WMAX);
    assign pow_ovf  = pow_prod > pow_lim;

    aic_engine #(.DATA_WIDTH(DATA_WIDTH)) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (eng_req),
        .i_x     (eng_x),
        .i_y     (eng_y),
        .o_done  (eng_done),
        .o_lo    (eng_lo),
        .o_hi    (eng_hi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_op) inside
                    OP_ADD, OP_SUB: n_state = ST_DONE;
                    OP_DIV, OP_REM: n_state = b_zero ? ST_DONE : ST_WAIT;
                    OP_POW: begin
                        n_state = (b_neg || b_zero || ma <= DW'(1)) ? ST_DONE : ST_POW_MUL;
                    end
                    OP_SQRT: n_state = b_neg ? ST_DONE : ST_WAIT;
                    default: n_state = ST_WAIT;
                endcase
            end
            ST_WAIT: begin
                if (eng_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_POW_MUL: n_state = ST_POW_WAIT;
            ST_POW_WAIT: begin
                if (eng_done) begin
                    n_state = (pow_ovf || r_cnt == DW'(1)) ? ST_DONE : ST_POW_MUL;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready    = (r_state == ST_IDLE);
        eng_req.start = 1'b0;
        eng_req.op    = EOP_MUL;
        eng_x         = r_a;
        eng_y         = r_b;
        unique case (r_state)
            ST_EXEC: begin
                case (r_op) inside
                    OP_MUL: eng_req.start = 1'b1;
                    OP_DIV, OP_REM: begin
                        eng_req.start = !b_zero;
                        eng_req.op    = EOP_DIV;
                        eng_x         = ma;
                        eng_y         = mb;
                    end
                    OP_SQRT: begin
                        eng_req.start = !b_neg;
                        eng_req.op    = EOP_SQRT;
                        eng_x         = r_b;
                    end
                    OP_CBRT: begin
                        eng_req.start = 1'b1;
                        eng_req.op    = EOP_CBRT;
                        eng_x         = mb;
                    end
                    default: begin
                    end
                endcase
            end
            ST_POW_MUL: begin
                eng_req.start = 1'b1;
                eng_x         = r_m;
                eng_y         = r_ma;
            end
            default: begin
            end
        endcase
        o_out.valid        = r_ov;
        o_out.result_value = r_out_val;
        o_out.error_code   = r_out_err;
    end

    // outcome known in the execute state: direct results and error cases
    always_comb begin
        ex_res   = '0;
        ex_err   = ERR_NONE;
        ex_store = 1'b1;
        case (r_op) inside
            OP_ADD: ex_res = r_a + r_b;
            OP_SUB: ex_res = r_a - r_b;
            OP_DIV, OP_REM: begin
                if (b_zero) begin
                    ex_err   = ERR_DIV_ZERO;
                    ex_store = 1'b0;
                end
            end
            OP_POW: begin
                if (b_neg) begin
                    if (ma == '0) begin
                        ex_err   = ERR_DIV_ZERO;
                        ex_store = 1'b0;
                    end else if (ma == DW'(1)) begin
                        ex_res = sgn(a_neg & r_b[0], DW'(1));
                    end
                end else if (b_zero) begin
                    ex_res = DW'(1);
                end else if (ma <= DW'(1)) begin
                    ex_res = sgn(a_neg & r_b[0], ma);
                end
            end
            OP_SQRT: begin
                if (b_neg) begin
                    ex_err   = ERR_NEG_ROOT;
                    ex_store = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // output valid flag and stored previous answer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_prev <= '0;
        end else begin
            if (r_state == ST_DONE && out_free) begin
                r_ov <= 1'b1;
                if (r_store) begin
                    r_prev <= r_res;
                end
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    r_op <= t_opcode'(i_in.opcode);
                    r_a  <= (a_w == '0) ? r_prev : a_w;
                    r_b  <= (b_w == '0) ? r_prev : b_w;
                end
            end
            ST_EXEC: begin
                r_err   <= ex_err;
                r_store <= ex_store;
                r_res   <= ex_res;
                r_m     <= DW'(1);
                r_ma    <= ma;
                r_cnt   <= mb;
                r_rneg  <= a_neg & r_b[0];
            end
            ST_WAIT: begin
                if (eng_done) begin
                    case (r_op)
                        OP_DIV: begin
                            if (!(a_neg ^ b_neg) && eng_lo[DW-1]) begin
                                r_res <= WMAX;
                                r_err <= ERR_OVERFLOW;
                            end else begin
                                r_res <= sgn(a_neg ^ b_neg, eng_lo);
                            end
                        end
                        OP_REM:  r_res <= sgn(a_neg, eng_hi);
                        OP_CBRT: r_res <= sgn(b_neg, eng_lo);
                        default: r_res <= eng_lo;
                    endcase
                end
            end
            ST_POW_WAIT: begin
                if (eng_done) begin
                    if (pow_ovf) begin
                        r_res <= r_rneg ? WSIGN : WMAX;
                        r_err <= ERR_OVERFLOW;
                    end else begin
                        r_m   <= eng_lo;
                        r_cnt <= r_cnt - DW'(1);
                        r_res <= sgn(r_rneg, eng_lo);
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out_val <= r_store ? FIELD_WIDTH'(signed'(r_res)) : '0;
                    r_out_err <= r_err;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### dv/accumulator_integer_calculator_tb.sv
// Self-checking testbench for the accumulator integer calculator.
`timescale 1ns / 1ps

module accumulator_integer_calculator_tb;
    import aic_pkg::*;

    localparam int  DW       = 32;
    localparam int  WD_LIMIT = 20000;
    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;

    typedef struct packed {
        t_opcode            op;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_calc_item;

    typedef struct packed {
        logic signed [31:0] value;
        t_err               err;
    } t_calc_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    aic_in_if  in_ch();
    aic_out_if out_ch();

    accumulator_integer_calculator #(.DATA_WIDTH(DW)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #1 i_clk = ~i_clk;

    t_calc_item   pending_items[$];
    t_calc_result expected_results[$];
    logic signed [31:0] model_answer;
    int  mismatches = 0;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles = 0;
    int  quiet_cycles = 0;

    // ---------------- predictor ----------------
    function automatic logic [63:0] sqrt_floor(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] cbrt_floor(logic [63:0] x);
        logic [63:0] y;
        logic [63:0] t;
        y = 0;
        for (int s = 63; s >= 0; s -= 3) begin
            y = y << 1;
            t = 3 * y * (y + 1) + 1;
            if ((x >> s) >= t) begin
                x = x - (t << s);
                y = y + 1;
            end
        end
        return y;
    endfunction

    function automatic logic [31:0] mag32(logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic t_calc_result calc_predict(t_calc_item it);
        t_calc_result res;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] m;
        logic [63:0] lim;
        logic neg;
        logic keep;
        a = (it.a == 0) ? model_answer : it.a;
        b = (it.b == 0) ? model_answer : it.b;
        ma = mag32(a);
        mb = mag32(b);
        res.value = 0;
        res.err = ERR_NONE;
        keep = 1'b1;
        case (it.op) inside
            OP_ADD: res.value = a + b;
            OP_SUB: res.value = a - b;
            OP_MUL: res.value = a * b;
            OP_DIV, OP_REM: begin
                if (b == 0) begin
                    res.err = ERR_DIV_ZERO;
                    keep = 1'b0;
                end else if (it.op == OP_DIV) begin
                    neg = a[31] ^ b[31];
                    if (!neg && (ma / mb) > 32'(MAXV)) begin
                        res.value = MAXV;
                        res.err = ERR_OVERFLOW;
                    end else begin
                        res.value = neg ? -$signed(ma / mb) : $signed(ma / mb);
                    end
                end else begin
                    res.value = a[31] ? -$signed(ma % mb) : $signed(ma % mb);
                end
            end
            OP_POW: begin
                neg = a[31] & b[0];
                if (b[31]) begin
                    if (ma == 0) begin
                        res.err = ERR_DIV_ZERO;
                        keep = 1'b0;
                    end else if (ma == 1) begin
                        res.value = neg ? -1 : 1;
                    end
                end else if (mb == 0) begin
                    res.value = 1;
                end else if (ma <= 1) begin
                    res.value = neg ? -$signed(ma) : $signed(ma);
                end else begin
                    lim = neg ? 64'h80000000 : 64'h7fffffff;
                    m = 1;
                    for (longint i = 0; i < mb; i++) begin
                        if (m > lim / ma) begin
                            res.err = ERR_OVERFLOW;
                            break;
                        end
                        m = m * ma;
                    end
                    if (res.err == ERR_OVERFLOW) res.value = neg ? MINV : MAXV;
                    else res.value = neg ? -$signed(m[31:0]) : $signed(m[31:0]);
                end
            end
            OP_SQRT: begin
                if (b[31]) begin
                    res.err = ERR_NEG_ROOT;
                    keep = 1'b0;
                end else begin
                    m = sqrt_floor({32'd0, b});
                    res.value = $signed(m[31:0]);
                end
            end
            default: begin
                m = cbrt_floor({32'd0, mb});
                res.value = b[31] ? -$signed(m[31:0]) : $signed(m[31:0]);
            end
        endcase
        if (keep) model_answer = res.value;
        else res.value = 0;
        return res;
    endfunction

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid     <= 1'b0;
            in_ch.opcode    <= '0;
            in_ch.operand_a <= '0;
            in_ch.operand_b <= '0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) expected_results.push_back(calc_predict(
                t_calc_item'{t_opcode'(in_ch.opcode), in_ch.operand_a, in_ch.operand_b}));
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                t_calc_item it;
                it = pending_items.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.opcode    <= it.op;
                in_ch.operand_a <= it.a;
                in_ch.operand_b <= it.b;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold, counted down on its own
    always @(posedge i_clk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // ---------------- receiver + monitor ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result value=%0d err=%0d", $time,
                             out_ch.result_value, out_ch.error_code);
                    mismatches++;
                end else begin
                    t_calc_result exp_r;
                    exp_r = expected_results.pop_front();
                    if (exp_r.value !== out_ch.result_value) begin
                        $display("%0t: result_value expected %0d actual %0d", $time,
                                 exp_r.value, out_ch.result_value);
                        mismatches++;
                    end
                    if (exp_r.err !== out_ch.error_code) begin
                        $display("%0t: error_code expected %0d actual %0d", $time,
                                 exp_r.err, out_ch.error_code);
                        mismatches++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog: cycles without any transfer outside a receiver hold
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_cycles > 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WD_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(5))
            0: return $signed($urandom_range(20)) - 10;
            1: return $signed($urandom_range(2000)) - 1000;
            2: return $urandom_range(1) ? MAXV : MINV;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic queue_item(t_opcode op, logic signed [31:0] a, logic signed [31:0] b);
        pending_items.push_back(t_calc_item'{op, a, b});
    endtask

    task automatic drain_all();
        wait (pending_items.size() == 0 && !in_ch.valid && expected_results.size() == 0);
    endtask

    initial begin
        t_opcode op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        model_answer   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corner cases
        queue_item(OP_ADD, MAXV, 1);
        queue_item(OP_SUB, MINV, 1);
        queue_item(OP_MUL, MAXV, MAXV);
        queue_item(OP_DIV, 7, 0);          // zero b selects previous answer
        queue_item(OP_SUB, 5, 5);          // answer becomes zero
        queue_item(OP_DIV, 9, 0);          // divide by zero
        queue_item(OP_REM, 9, 0);          // remainder by zero
        queue_item(OP_DIV, MINV, -1);      // saturates
        queue_item(OP_REM, MINV, -1);
        queue_item(OP_DIV, -7, 2);
        queue_item(OP_REM, -7, 2);
        queue_item(OP_POW, 2, 31);         // overflow
        queue_item(OP_POW, -2, 31);        // exactly most negative
        queue_item(OP_POW, -3, 41);        // negative overflow
        queue_item(OP_POW, -1, -3);
        queue_item(OP_POW, 1, -4);
        queue_item(OP_POW, 5, -2);
        queue_item(OP_SUB, 3, 3);
        queue_item(OP_POW, 0, -1);         // zero to negative power
        queue_item(OP_SQRT, 1, MAXV);
        queue_item(OP_SQRT, 1, -4);        // negative root
        queue_item(OP_CBRT, 1, MINV);
        queue_item(OP_CBRT, 1, 27);
        queue_item(OP_POW, 3, 0);
        drain_all();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? 87 : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? 87 : 0;
            if (ph == 3) begin
                send_idle_pct  = 15;
                recv_stall_pct = 15;
            end
            if (ph == 0) hold_cycles = 300;   // long stall while items keep coming
            for (int i = 0; i < 250; i++) begin
                op = t_opcode'($urandom_range(7));
                a = rand_operand();
                b = rand_operand();
                if (op == OP_POW && $urandom_range(1)) b = $signed($urandom_range(40)) - 5;
                queue_item(op, a, b);
            end
            drain_all();
        end
        repeat (DW * (DW + 4) + 50) @(posedge i_clk);
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule

### files.f
hdl/aic_pkg.sv
hdl/aic_if.sv
hdl/aic_engine.sv
hdl/accumulator_integer_calculator.sv
dv/accumulator_integer_calculator_tb.sv
